FILE: rtl/core/vfdenc_pkg.sv
// Shared constants, codes and CRC helper for the spindle command frame encoder.
`default_nettype none

package vfdenc_pkg;

   // Command codes on req_func
   localparam logic [1:0] FUNC_STOP    = 2'd0;
   localparam logic [1:0] FUNC_RUN_CW  = 2'd1;
   localparam logic [1:0] FUNC_RUN_CCW = 2'd2;
   localparam logic [1:0] FUNC_SPEED   = 2'd3;

   // Frame bytes
   localparam logic [7:0] ADDR_RESET  = 8'h01;
   localparam logic [7:0] CMD_STATE   = 8'h03;
   localparam logic [7:0] LEN_STATE   = 8'h01;
   localparam logic [7:0] CMD_SPEED   = 8'h05;
   localparam logic [7:0] LEN_SPEED   = 8'h02;
   localparam logic [7:0] CODE_STOP   = 8'h08;
   localparam logic [7:0] CODE_RUN_CW = 8'h01;
   localparam logic [7:0] CODE_RUN_CCW = 8'h11;

   // CRC-16, reflected
   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Byte positions across the state frame and the speed frame
   localparam int unsigned POS_W = 4;
   localparam logic [POS_W-1:0] POS_ST_ADDR   = 4'd0;
   localparam logic [POS_W-1:0] POS_ST_CMD    = 4'd1;
   localparam logic [POS_W-1:0] POS_ST_LEN    = 4'd2;
   localparam logic [POS_W-1:0] POS_ST_CODE   = 4'd3;
   localparam logic [POS_W-1:0] POS_ST_CRC_LO = 4'd4;
   localparam logic [POS_W-1:0] POS_ST_CRC_HI = 4'd5;
   localparam logic [POS_W-1:0] POS_SP_ADDR   = 4'd6;
   localparam logic [POS_W-1:0] POS_SP_CMD    = 4'd7;
   localparam logic [POS_W-1:0] POS_SP_LEN    = 4'd8;
   localparam logic [POS_W-1:0] POS_SP_VAL_HI = 4'd9;
   localparam logic [POS_W-1:0] POS_SP_VAL_LO = 4'd10;
   localparam logic [POS_W-1:0] POS_SP_CRC_LO = 4'd11;
   localparam logic [POS_W-1:0] POS_SP_CRC_HI = 4'd12;

   // rpm * 5 / 3: x = rpm * 5 fits 19 bits; x / 3 = (x * ceil(2^20 / 3)) >> 20
   localparam int unsigned SCALED_W    = 19;
   localparam int unsigned RECIP_SHIFT = 20;
   localparam logic [RECIP_SHIFT-1:0] RECIP_THIRD = 20'd349526;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vfd_command_frame_encoder_core.sv
// Top level of the spindle command frame encoder: command register, byte sequencer, output register.
// The request beat is accepted into the command register, and the first byte of a command is then
// loaded into the rsp register when the output register is free (rsp_stall can hold it).
// Throughput: one byte per cycle from a single output register while rsp_stall is low; a stop
// command sends 6 bytes, a run command 13 and a speed-only command 7, and the next command is
// taken in the cycle its final byte is loaded, so commands stream back to back.
// Reset: synchronous, active high; clears the pipeline and sets the device address to 0x01.
`default_nettype none

module vfd_command_frame_encoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [15:0] req_rpm,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [7:0]  rsp_tx_byte,
   output logic             rsp_frame_end,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic                           cmd_valid_ff, cmd_valid_in;
   logic [1:0]                     func_ff;
   logic [15:0]                    speed_ff;
   logic [vfdenc_pkg::POS_W-1:0]   idx_ff, idx_in;
   logic [15:0]                    crc_ff, crc_in;
   logic [7:0]                     addr_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_byte_ff;
   logic                           rsp_frame_end_ff;
   logic                           rsp_last_ff;

   logic [15:0]                    req_speed;
   logic [7:0]                     gen_byte;
   logic [7:0]                     gen_code;
   logic                           gen_body;
   logic                           gen_frame_end;
   logic                           gen_last;
   logic                           gen_fire;
   logic                           out_free;
   logic                           req_accept;

   vfdenc_speed_scale u_speed_scale (
      .rpm   (req_rpm),
      .speed (req_speed)
   );

   always_comb begin
      case (func_ff)
         vfdenc_pkg::FUNC_STOP:    gen_code = vfdenc_pkg::CODE_STOP;
         vfdenc_pkg::FUNC_RUN_CW:  gen_code = vfdenc_pkg::CODE_RUN_CW;
         vfdenc_pkg::FUNC_RUN_CCW: gen_code = vfdenc_pkg::CODE_RUN_CCW;
         default:                  gen_code = vfdenc_pkg::CODE_STOP;
      endcase
   end

   always_comb begin
      gen_body = 1'b1;
      case (idx_ff)
         vfdenc_pkg::POS_ST_ADDR:   gen_byte = addr_ff;
         vfdenc_pkg::POS_ST_CMD:    gen_byte = vfdenc_pkg::CMD_STATE;
         vfdenc_pkg::POS_ST_LEN:    gen_byte = vfdenc_pkg::LEN_STATE;
         vfdenc_pkg::POS_ST_CODE:   gen_byte = gen_code;
         vfdenc_pkg::POS_ST_CRC_LO: begin
            gen_byte = crc_ff[7:0];
            gen_body = 1'b0;
         end
         vfdenc_pkg::POS_ST_CRC_HI: begin
            gen_byte = crc_ff[15:8];
            gen_body = 1'b0;
         end
         vfdenc_pkg::POS_SP_ADDR:   gen_byte = addr_ff;
         vfdenc_pkg::POS_SP_CMD:    gen_byte = vfdenc_pkg::CMD_SPEED;
         vfdenc_pkg::POS_SP_LEN:    gen_byte = vfdenc_pkg::LEN_SPEED;
         vfdenc_pkg::POS_SP_VAL_HI: gen_byte = speed_ff[15:8];
         vfdenc_pkg::POS_SP_VAL_LO: gen_byte = speed_ff[7:0];
         vfdenc_pkg::POS_SP_CRC_LO: begin
            gen_byte = crc_ff[7:0];
            gen_body = 1'b0;
         end
         vfdenc_pkg::POS_SP_CRC_HI: begin
            gen_byte = crc_ff[15:8];
            gen_body = 1'b0;
         end
         default: begin
            gen_byte = 8'h00;
            gen_body = 1'b0;
         end
      endcase
   end

   always_comb begin
      gen_frame_end = (idx_ff == vfdenc_pkg::POS_ST_CRC_HI) ||
                      (idx_ff == vfdenc_pkg::POS_SP_CRC_HI);
      gen_last      = (idx_ff == vfdenc_pkg::POS_SP_CRC_HI) ||
                      ((idx_ff == vfdenc_pkg::POS_ST_CRC_HI) &&
                       (func_ff == vfdenc_pkg::FUNC_STOP));
      out_free      = !rsp_valid_ff || !rsp_stall;
      gen_fire      = cmd_valid_ff && out_free;
      // take the next command in the cycle the final byte leaves the sequencer
      req_stall     = cmd_valid_ff && !(gen_fire && gen_last);
      req_accept    = req_valid && !req_stall;
   end

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      if (gen_fire) begin
         idx_in = idx_ff + 1'b1;
         if (gen_last) begin
            cmd_valid_in = 1'b0;
         end
         if (gen_frame_end) begin
            crc_in = vfdenc_pkg::CRC_SEED;
         end else if (gen_body) begin
            crc_in = vfdenc_pkg::crc_update(crc_ff, gen_byte);
         end
      end
      if (req_accept) begin
         cmd_valid_in = 1'b1;
         idx_in       = (req_func == vfdenc_pkg::FUNC_SPEED) ? vfdenc_pkg::POS_SP_ADDR
                                                             : vfdenc_pkg::POS_ST_ADDR;
      end
      rsp_valid_in = gen_fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         idx_ff       <= vfdenc_pkg::POS_ST_ADDR;
         crc_ff       <= vfdenc_pkg::CRC_SEED;
         addr_ff      <= vfdenc_pkg::ADDR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            addr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff  <= req_func;
         speed_ff <= req_speed;
      end
      if (gen_fire) begin
         rsp_byte_ff      <= gen_byte;
         rsp_frame_end_ff <= gen_frame_end;
         rsp_last_ff      <= gen_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = rsp_byte_ff;
   assign rsp_frame_end = rsp_frame_end_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/vfdenc_speed_scale.sv
// Converts rpm to the drive frequency value floor(rpm * 5 / 3), saturated to 16 bits.
`default_nettype none

module vfdenc_speed_scale (
   input  wire logic [15:0] rpm,
   output logic      [15:0] speed
);

   logic [vfdenc_pkg::SCALED_W-1:0]                             scaled;
   logic [vfdenc_pkg::SCALED_W+vfdenc_pkg::RECIP_SHIFT-1:0]     prod;
   logic [vfdenc_pkg::SCALED_W-1:0]                             quot;

   always_comb begin
      scaled = {1'b0, rpm, 2'b00} + {3'b000, rpm};
      prod   = {{vfdenc_pkg::RECIP_SHIFT{1'b0}}, scaled}
               * {{vfdenc_pkg::SCALED_W{1'b0}}, vfdenc_pkg::RECIP_THIRD};
      quot   = prod[vfdenc_pkg::SCALED_W+vfdenc_pkg::RECIP_SHIFT-1:vfdenc_pkg::RECIP_SHIFT];
      // saturate to the 16-bit frame field
      if (|quot[vfdenc_pkg::SCALED_W-1:16]) begin
         speed = 16'hFFFF;
      end else begin
         speed = quot[15:0];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/vfdenc_checker.sv
// Port-level assertions for the spindle command frame encoder, bound to the top level.
`default_nettype none

module vfdenc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic        rsp_frame_end,
   input wire logic        rsp_last
);

   // no beat survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a command always ends on the closing CRC byte of a frame
   a_last_closes_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_frame_end)
      else $error("last byte is not a frame end");

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte) &&
                                 $stable(rsp_frame_end) && $stable(rsp_last))
      else $error("stalled response beat changed");

   // a new command is taken only while the sequencer loads the closing byte or is idle
   a_accept_when_draining: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && rsp_valid && rsp_stall |=> rsp_valid && rsp_last)
      else $error("command accepted while an earlier command is still mid-frame");

endmodule

bind vfd_command_frame_encoder_core vfdenc_checker u_vfdenc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_tx_byte   (rsp_tx_byte),
   .rsp_frame_end (rsp_frame_end),
   .rsp_last      (rsp_last)
);

`default_nettype wire
